// File: design/lfu_pkg.sv
// Shared types and constants for the LFU cache with LRU tie-break.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package lfu_pkg;

  // Fixed field widths
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned EVKEY_W = 16;

  localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
  localparam logic [VALUE_W-1:0] READ_MISS  = 32'hFFFF_FFFF;
  localparam logic [VALUE_W-1:0] READ_PUT   = 32'h0000_0000;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;      // capture the request
    logic lookup;     // register key match result
    logic touch;      // bump count, make pointed entry most recent
    logic ram_rd;     // read value at pointer
    logic ram_wr;     // write request value at pointer
    logic scan_init;  // start victim search
    logic scan_step;  // examine one entry
    logic evict;      // remove pointed entry
    logic set_free;   // point at lowest free slot
    logic insert;     // fill pointed slot
    logic respond;    // load the result register
  } lfu_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hit;
    logic put;
    logic cap_zero;
    logic full;
    logic scan_last;
    logic out_free;
  } lfu_sts_t;

endpackage

`default_nettype wire

// File: design/lfu_intf.sv
// Request and response channel interfaces of the LFU cache.
// Depends on lfu_pkg for the fixed field widths.
`default_nettype none

interface lfu_req_if #(
  parameter int unsigned KEY_BITS = 16
);
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [KEY_BITS-1:0]                 key;
  logic signed [lfu_pkg::VALUE_W-1:0]  write_value;

  modport source (output valid, operation, key, write_value, input ready);
  modport sink   (input valid, operation, key, write_value, output ready);
endinterface

interface lfu_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic signed [lfu_pkg::VALUE_W-1:0]  read_value;
  logic                                evicted;
  logic [lfu_pkg::EVKEY_W-1:0]         evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

`default_nettype wire

// File: design/lfu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lfu_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [AW-1:0]           waddr_i,
  input  wire logic [WIDTH-1:0]        wdata_i,
  input  wire logic                    re_i,
  input  wire logic [AW-1:0]           raddr_i,
  output      logic [WIDTH-1:0]        rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

`default_nettype wire

// File: design/lfu_ctrl.sv
// Controller state machine of the LFU cache: sequences lookup, victim search,
// eviction, insertion and the response. Depends on lfu_pkg.
`default_nettype none

module lfu_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire lfu_pkg::lfu_sts_t sts_i,
  output      lfu_pkg::lfu_cmd_t cmd_o
);
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_SCAN,
    S_EVICT,
    S_INSERT,
    S_RESPOND
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && ready_q) begin
          cmd_o.latch = 1'b1;
          state_d     = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts_i.put) begin
          cmd_o.touch  = sts_i.hit;
          cmd_o.ram_rd = sts_i.hit;
          state_d      = S_RESPOND;
        end else if (sts_i.cap_zero) begin
          state_d = S_RESPOND;
        end else if (sts_i.hit) begin
          cmd_o.touch  = 1'b1;
          cmd_o.ram_wr = 1'b1;
          state_d      = S_RESPOND;
        end else if (sts_i.full) begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end else begin
          cmd_o.set_free = 1'b1;
          state_d        = S_INSERT;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_EVICT;
        end
      end
      S_EVICT: begin
        cmd_o.evict    = 1'b1;
        cmd_o.set_free = 1'b1;
        state_d        = S_INSERT;
      end
      S_INSERT: begin
        cmd_o.insert = 1'b1;
        cmd_o.ram_wr = 1'b1;
        state_d      = S_RESPOND;
      end
      S_RESPOND: begin
        if (sts_i.out_free) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign ready_d = (state_d == S_IDLE);

  // State and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

  assign in_ready_o = ready_q;
endmodule

`default_nettype wire

// File: design/lfu_dp.sv
// Datapath of the LFU cache: entry keys, use counts, recency ranks, valid bits,
// occupancy, capacity register, victim search registers and the result register.
// Depends on lfu_pkg and lfu_ram.
`default_nettype none

module lfu_dp #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lfu_pkg::CAP_W-1:0]     cfg_wdata_i,
  input  wire logic                          in_operation_i,
  input  wire logic [KEY_BITS-1:0]           in_key_i,
  input  wire logic [lfu_pkg::VALUE_W-1:0]   in_write_value_i,
  input  wire lfu_pkg::lfu_cmd_t             cmd_i,
  output      lfu_pkg::lfu_sts_t             sts_o,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic                          out_hit_o,
  output      logic [lfu_pkg::VALUE_W-1:0]   out_read_value_o,
  output      logic                          out_evicted_o,
  output      logic [lfu_pkg::EVKEY_W-1:0]   out_evicted_key_o
);
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [CMP_W-1:0]      ENT_CMP   = CMP_W'(ENTRIES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // Request registers
  lfu_pkg::op_e                op_q;
  logic [KEY_BITS-1:0]         key_q;
  logic [lfu_pkg::VALUE_W-1:0] wval_q;
  logic                        hit_q;
  logic [IDX_W-1:0]            ptr_q, ptr_d;

  // Entry state
  logic                        valid_q [ENTRIES];
  logic                        valid_d [ENTRIES];
  logic [KEY_BITS-1:0]         ekey_q  [ENTRIES];
  logic [COUNT_BITS-1:0]       cnt_q   [ENTRIES];
  logic [IDX_W-1:0]            rank_q  [ENTRIES];
  logic [IDX_W-1:0]            rank_d  [ENTRIES];
  logic [OCC_W-1:0]            occ_q, occ_d;
  logic [lfu_pkg::CAP_W-1:0]   cap_q;

  // Victim search
  logic                        have_q;
  logic [IDX_W-1:0]            best_idx_q;
  logic [COUNT_BITS-1:0]       best_cnt_q;
  logic [IDX_W-1:0]            best_rank_q;

  // Per-item eviction report
  logic                        ev_q;
  logic [lfu_pkg::EVKEY_W-1:0] evkey_q;

  // Result register
  logic                        out_valid_q;
  logic                        out_hit_q;
  logic [lfu_pkg::VALUE_W-1:0] out_value_q;
  logic                        out_ev_q;
  logic [lfu_pkg::EVKEY_W-1:0] out_evkey_q;

  logic                        match_any;
  logic [IDX_W-1:0]            match_idx;
  logic                        free_any;
  logic [IDX_W-1:0]            free_idx;
  logic [IDX_W-1:0]            ptr_rank;
  logic [COUNT_BITS-1:0]       ptr_cnt;
  logic                        take;
  logic [CMP_W-1:0]            cap_ext, cap_eff;
  logic [lfu_pkg::VALUE_W-1:0] ram_rdata;
  logic [lfu_pkg::VALUE_W-1:0] res_value;
  logic                        out_free;

  // Find the lowest valid entry holding the request key
  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (valid_q[j] && ekey_q[j] == key_q && !match_any) begin
        match_any = 1'b1;
        match_idx = IDX_W'(j);
      end
    end
  end

  // Find the lowest free slot, counting the slot being evicted as free
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      if ((!valid_q[j] || (cmd_i.evict && ptr_q == IDX_W'(j))) && !free_any) begin
        free_any = 1'b1;
        free_idx = IDX_W'(j);
      end
    end
  end

  assign ptr_rank = rank_q[ptr_q];
  assign ptr_cnt  = cnt_q[ptr_q];

  // Candidate beats the best so far: lower count, or same count and less recent
  assign take = valid_q[ptr_q] &&
                (!have_q || ptr_cnt < best_cnt_q ||
                 (ptr_cnt == best_cnt_q && ptr_rank < best_rank_q));

  // Effective capacity, clamped to the number of slots
  assign cap_ext = CMP_W'(cap_q);
  assign cap_eff = (cap_ext > ENT_CMP) ? ENT_CMP : cap_ext;

  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.hit       = hit_q;
  assign sts_o.put       = (op_q == lfu_pkg::OP_PUT);
  assign sts_o.cap_zero  = (cap_q == '0);
  assign sts_o.full      = (CMP_W'(occ_q) >= cap_eff) && (occ_q != '0);
  assign sts_o.scan_last = (ptr_q == LAST_IDX);
  assign sts_o.out_free  = out_free;

  // Pointer: match, scan position, victim or free slot
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.lookup) begin
      ptr_d = match_idx;
    end else if (cmd_i.scan_init) begin
      ptr_d = '0;
    end else if (cmd_i.scan_step) begin
      if (ptr_q == LAST_IDX) begin
        ptr_d = take ? ptr_q : best_idx_q;
      end else begin
        ptr_d = ptr_q + IDX_W'(1);
      end
    end else if (cmd_i.set_free) begin
      ptr_d = free_idx;
    end
  end

  // Valid bits, ranks and occupancy
  always_comb begin
    occ_d = occ_q;
    for (int j = 0; j < ENTRIES; j++) begin
      valid_d[j] = valid_q[j];
      rank_d[j]  = rank_q[j];
      // Close the gap left by the touched or evicted entry's rank
      if ((cmd_i.touch || cmd_i.evict) && valid_q[j] && rank_q[j] > ptr_rank) begin
        rank_d[j] = rank_q[j] - IDX_W'(1);
      end
      if (ptr_q == IDX_W'(j)) begin
        if (cmd_i.touch) begin
          rank_d[j] = IDX_W'(occ_q - OCC_W'(1));
        end
        if (cmd_i.evict) begin
          valid_d[j] = 1'b0;
        end
        if (cmd_i.insert) begin
          valid_d[j] = 1'b1;
          rank_d[j]  = IDX_W'(occ_q);
        end
      end
    end
    if (cmd_i.evict) begin
      occ_d = occ_q - OCC_W'(1);
    end else if (cmd_i.insert) begin
      occ_d = occ_q + OCC_W'(1);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < ENTRIES; j++) begin
        valid_q[j] <= 1'b0;
      end
      occ_q       <= '0;
      cap_q       <= lfu_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      for (int j = 0; j < ENTRIES; j++) begin
        valid_q[j] <= valid_d[j];
      end
      occ_q <= occ_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.respond) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Entry payload: keys, counts, ranks
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < ENTRIES; j++) begin
      rank_q[j] <= rank_d[j];
      if (ptr_q == IDX_W'(j)) begin
        if (cmd_i.insert) begin
          ekey_q[j] <= key_q;
          cnt_q[j]  <= COUNT_ONE;
        end else if (cmd_i.touch && cnt_q[j] != COUNT_MAX) begin
          cnt_q[j] <= cnt_q[j] + COUNT_ONE;
        end
      end
    end
  end

  // Request, search and report registers
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.latch) begin
      op_q    <= lfu_pkg::op_e'(in_operation_i);
      key_q   <= in_key_i;
      wval_q  <= in_write_value_i;
      ev_q    <= 1'b0;
      evkey_q <= '0;
    end
    if (cmd_i.lookup) begin
      hit_q <= match_any;
    end
    if (cmd_i.scan_init) begin
      have_q <= 1'b0;
    end else if (cmd_i.scan_step && take) begin
      have_q      <= 1'b1;
      best_idx_q  <= ptr_q;
      best_cnt_q  <= ptr_cnt;
      best_rank_q <= ptr_rank;
    end
    if (cmd_i.evict) begin
      ev_q    <= 1'b1;
      evkey_q <= lfu_pkg::EVKEY_W'(ekey_q[ptr_q]);
    end
  end

  // Stored values
  lfu_ram #(
    .WIDTH (lfu_pkg::VALUE_W),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_wr),
    .waddr_i (ptr_q),
    .wdata_i (wval_q),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  // Result value: stored value on a get hit, all ones on a miss, zero for a put
  always_comb begin
    if (op_q == lfu_pkg::OP_PUT) begin
      res_value = lfu_pkg::READ_PUT;
    end else if (hit_q) begin
      res_value = ram_rdata;
    end else begin
      res_value = lfu_pkg::READ_MISS;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      out_hit_q   <= hit_q;
      out_value_q <= res_value;
      out_ev_q    <= ev_q;
      out_evkey_q <= evkey_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_hit_o         = out_hit_q;
  assign out_read_value_o  = out_value_q;
  assign out_evicted_o     = out_ev_q;
  assign out_evicted_key_o = out_evkey_q;
endmodule

`default_nettype wire

// File: design/lfu_cache_with_lru_tiebreak.sv
// Fully associative key/value cache with least-frequently-used replacement and a
// least-recently-used tie-break. Each request is a get or a put and yields one
// response. Any get, a hitting put and a put with capacity zero pass lookup and
// decide to the response; a put into a free slot adds an insert step. A put that
// must evict first walks every slot once to find the victim, one slot per cycle,
// then evicts it and inserts. A response waiting in the output register holds the
// next one back in its last step. One request is in work at a time; the next
// request is accepted while the previous response waits in the output register.
// The user must write capacity through cfg_we_i/cfg_wdata_i only while no request
// is in work; the block does not enforce this. Values above ENTRIES act as
// ENTRIES. Depends on lfu_pkg, lfu_intf, lfu_ram, lfu_ctrl and lfu_dp.
`default_nettype none

module lfu_cache_with_lru_tiebreak #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [lfu_pkg::CAP_W-1:0] cfg_wdata_i,
  lfu_req_if.sink                        req_i,
  lfu_rsp_if.source                      rsp_o
);
  lfu_pkg::lfu_cmd_t           cmd;
  lfu_pkg::lfu_sts_t           sts;
  logic                        in_ready;
  logic [lfu_pkg::VALUE_W-1:0] read_value;

  // Sequencer
  lfu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Entry storage and result
  lfu_dp #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_operation_i    (req_i.operation),
    .in_key_i          (req_i.key),
    .in_write_value_i  (req_i.write_value),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (rsp_o.valid),
    .out_ready_i       (rsp_o.ready),
    .out_hit_o         (rsp_o.hit),
    .out_read_value_o  (read_value),
    .out_evicted_o     (rsp_o.evicted),
    .out_evicted_key_o (rsp_o.evicted_key)
  );

  assign req_i.ready      = in_ready;
  assign rsp_o.read_value = $signed(read_value);
endmodule

`default_nettype wire
